// ===== rtl/core/rc_pulse_demand_calibrator_defines.svh =====
// ----------------------------------------------------------------------------
// RC pulse demand calibrator assertion macros
// Shared property forms for the checker; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_DEMAND_CALIBRATOR_DEFINES_SVH
`define RC_PULSE_DEMAND_CALIBRATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCPDC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rcpdc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RCPDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rcpdc assertion failed");

`endif

// ===== rtl/core/rcpdc_pkg.sv =====
// ----------------------------------------------------------------------------
// RC pulse demand calibrator package
// Payload types, register codes and divider sizing shared by the design and testbench files.
// ----------------------------------------------------------------------------
package rcpdc_pkg;

	localparam int WidthW   = 16;
	localparam int DemandW  = 32;
	localparam int FracBits = 16;
	localparam int DivSteps = DemandW;
	localparam int DivCntW  = $clog2(DivSteps);
	localparam int CfgIdxW  = 2;

	localparam logic [CfgIdxW-1:0] CfgStartShortest = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgStartLongest  = 2'd1;

	localparam logic [WidthW-1:0] StartShortestRst = 16'd1250;
	localparam logic [WidthW-1:0] StartLongestRst  = 16'd1750;

	typedef struct packed {
		logic              mode;
		logic [WidthW-1:0] rise_capture;
		logic [WidthW-1:0] fall_capture;
	} item_t;

	typedef struct packed {
		logic [DemandW-1:0] demand;
		logic [WidthW-1:0]  pulse_width;
		logic [WidthW-1:0]  shortest_now;
		logic [WidthW-1:0]  longest_now;
		logic               range_zero;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== rtl/core/rcpdc_ifs.sv =====
// ----------------------------------------------------------------------------
// RC pulse demand calibrator channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface rcpdc_item_if;
	import rcpdc_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rcpdc_result_if;
	import rcpdc_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rcpdc_cfg_if;
	import rcpdc_pkg::*;
	logic               valid;
	logic               ready;
	logic [CfgIdxW-1:0] index;
	logic [WidthW-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rcpdc_div.sv =====
// ----------------------------------------------------------------------------
// RC pulse demand calibrator divider
// Restoring unsigned 32 by 16 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcpdc_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [rcpdc_pkg::DemandW-1:0]   dividend,
	input  logic [rcpdc_pkg::WidthW-1:0]    divisor,
	output logic [rcpdc_pkg::DemandW-1:0]   quotient,
	output rcpdc_pkg::div_status_t          status
);
	import rcpdc_pkg::*;

	logic [DemandW-1:0] quo_q;
	logic [WidthW-1:0]  rem_q;
	logic [WidthW-1:0]  divisor_q;
	logic [DivCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [WidthW:0]    trial;
	logic [WidthW:0]    diff;
	logic               ge;

	// The partial remainder stays below the divisor, so the shifted trial fits
	// one extra bit and the difference fits back into the remainder width.
	assign trial = {rem_q, quo_q[DemandW-1]};
	assign ge    = (trial >= {1'b0, divisor_q});
	assign diff  = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DivCntW'(DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DemandW-2:0], ge};
			rem_q <= ge ? diff[WidthW-1:0] : trial[WidthW-1:0];
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

// ===== rtl/core/rc_pulse_demand_calibrator.sv =====
// ----------------------------------------------------------------------------
// RC pulse demand calibrator
// Turns RC pulse edge captures into a self-calibrating speed demand.
// ----------------------------------------------------------------------------
// One item is handled at a time. For a measured pulse the calibration is
// updated at the item transfer itself; the PREP state then forms range and
// offset and starts the bit-serial divider, which produces one quotient bit
// per cycle; the DIV state takes the quotient when the divider is done, and
// the DONE state loads the result into the output register once it is free.
// A restart item or a zero range skips the divider. The next item is taken
// once the result is loaded, even while that result still waits for its
// transfer. Register writes are taken at any time.
module rc_pulse_demand_calibrator (
	input  logic                  clk,
	input  logic                  arst_n,
	rcpdc_cfg_if.sink             cfg,
	rcpdc_item_if.sink            item,
	rcpdc_result_if.source        result
);
	import rcpdc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [WidthW-1:0]  start_shortest_q;
	logic [WidthW-1:0]  start_longest_q;
	logic [WidthW-1:0]  longest_q;
	logic [WidthW-1:0]  shortest_q;
	logic [WidthW-1:0]  width_q;
	logic               mode_q;
	logic [DemandW-1:0] demand_q;
	logic               zero_q;
	result_t            out_q;
	logic               out_valid_q;

	logic [WidthW-1:0]  meas_width;
	logic [WidthW-1:0]  range;
	logic [WidthW-1:0]  offset;
	logic               item_xfer;
	logic               out_free;
	logic               div_start;
	logic [DemandW-1:0] div_quotient;
	div_status_t        div_status;

	assign cfg.ready  = 1'b1;
	assign item.ready = (state_q == ST_IDLE);
	assign item_xfer  = item.valid && item.ready;
	assign out_free   = !out_valid_q || result.ready;

	assign meas_width = item.data.fall_capture - item.data.rise_capture;
	assign range      = longest_q - shortest_q;
	assign offset     = width_q - shortest_q;
	assign div_start  = (state_q == ST_PREP) && !mode_q && (range != '0);

	rcpdc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({offset, {FracBits{1'b0}}}),
		.divisor  (range),
		.quotient (div_quotient),
		.status   (div_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_shortest_q <= StartShortestRst;
			start_longest_q  <= StartLongestRst;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CfgStartShortest: start_shortest_q <= cfg.data;
				CfgStartLongest:  start_longest_q  <= cfg.data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			longest_q   <= StartLongestRst;
			shortest_q  <= StartShortestRst;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_xfer) begin
						if (item.data.mode) begin
							longest_q  <= start_longest_q;
							shortest_q <= start_shortest_q;
						end else if (meas_width > longest_q) begin
							longest_q <= meas_width;
						end else if (meas_width < shortest_q) begin
							// The shortest only moves when the longest held.
							shortest_q <= meas_width;
						end
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= div_start ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					if (div_status.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers, no reset needed.
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			mode_q  <= item.data.mode;
			width_q <= item.data.mode ? '0 : meas_width;
		end
		if (state_q == ST_PREP) begin
			demand_q <= '0;
			zero_q   <= !mode_q && (range == '0);
		end
		if ((state_q == ST_DIV) && div_status.done) begin
			demand_q <= div_quotient;
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_q.demand       <= demand_q;
			out_q.pulse_width  <= width_q;
			out_q.shortest_now <= shortest_q;
			out_q.longest_now  <= longest_q;
			out_q.range_zero   <= zero_q;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule

// ===== rtl/core/rcpdc_checker.sv =====
// ----------------------------------------------------------------------------
// RC pulse demand calibrator checker
// Port-level assertions on the calibrator, attached by bind.
// ----------------------------------------------------------------------------
`include "rc_pulse_demand_calibrator_defines.svh"

module rcpdc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input logic                result_valid,
	input logic                result_ready,
	input rcpdc_pkg::result_t  result_data
);
	import rcpdc_pkg::*;

	// A stalled result keeps its valid and its payload.
	`RCPDC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_data))

	// The block is busy in the cycle after an item transfer.
	`RCPDC_ASSERT_NEXT(a_busy_after_item, item_valid && item_ready, !item_ready)

	// A zero range is only flagged when both reported limits are equal.
	`RCPDC_ASSERT_SAME(a_zero_range_limits, result_valid && result_data.range_zero, result_data.shortest_now == result_data.longest_now)

	// A flagged zero range forces the demand to zero.
	`RCPDC_ASSERT_SAME(a_zero_range_demand, result_valid && result_data.range_zero, result_data.demand == '0)

endmodule

bind rc_pulse_demand_calibrator rcpdc_checker u_rcpdc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

// ===== tb/sv/rc_pulse_demand_calibrator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC pulse demand calibrator checker
// Watches the register, item and result channels and keeps its own copy of
// the calibration state. Each item transfer yields one predicted result. Each
// result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rc_pulse_demand_calibrator_checker
	import rcpdc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	rcpdc_cfg_if    cfg,
	rcpdc_item_if   item,
	rcpdc_result_if result,
	output int      fail_count,
	output int      results_due
);

	localparam int ReportLimit = 10;

	logic [WidthW-1:0] start_shortest_q;
	logic [WidthW-1:0] start_longest_q;
	logic [WidthW-1:0] cal_shortest;
	logic [WidthW-1:0] cal_longest;
	result_t           demand_q[$];

	// Updates the calibration for one item and returns the result it causes.
	function automatic result_t calibrate(input item_t x);
		result_t           r;
		logic [WidthW-1:0] span;
		logic [WidthW-1:0] offset;
		r = '0;
		if (x.mode) begin
			// A set mode bit reloads both limits; the captures are ignored.
			cal_longest  = start_longest_q;
			cal_shortest = start_shortest_q;
		end else begin
			r.pulse_width = x.fall_capture - x.rise_capture;
			// The shortest is only looked at when the longest did not grow.
			if (r.pulse_width > cal_longest) begin
				cal_longest = r.pulse_width;
			end else if (r.pulse_width < cal_shortest) begin
				cal_shortest = r.pulse_width;
			end
			span   = cal_longest - cal_shortest;
			offset = r.pulse_width - cal_shortest;
			if (span == '0) begin
				r.range_zero = 1'b1;
			end else begin
				r.demand = {offset, {FracBits{1'b0}}} / {{(DemandW-WidthW){1'b0}}, span};
			end
		end
		r.shortest_now = cal_shortest;
		r.longest_now  = cal_longest;
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [DemandW-1:0] want,
			input logic [DemandW-1:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= ReportLimit) begin
				$display("%t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			start_shortest_q = StartShortestRst;
			start_longest_q  = StartLongestRst;
			cal_shortest     = StartShortestRst;
			cal_longest      = StartLongestRst;
			demand_q.delete();
			fail_count  = 0;
			results_due = 0;
		end else begin
			// The result of an item never leaves in the cycle of its own
			// transfer, so results are matched before new items are queued.
			if (result.valid && result.ready) begin
				if (demand_q.size() == 0) begin
					fail_count++;
					if (fail_count <= ReportLimit) begin
						$display("%t: result transfer with no result expected", $time);
					end
				end else begin
					want = demand_q.pop_front();
					check_field("demand", want.demand, result.data.demand);
					check_field("pulse_width", DemandW'(want.pulse_width),
						DemandW'(result.data.pulse_width));
					check_field("shortest_now", DemandW'(want.shortest_now),
						DemandW'(result.data.shortest_now));
					check_field("longest_now", DemandW'(want.longest_now),
						DemandW'(result.data.longest_now));
					check_field("range_zero", DemandW'(want.range_zero),
						DemandW'(result.data.range_zero));
				end
			end
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CfgStartShortest) begin
					start_shortest_q = cfg.data;
				end else if (cfg.index == CfgStartLongest) begin
					start_longest_q = cfg.data;
				end
			end
			if (item.valid && item.ready) begin
				demand_q.push_back(calibrate(item.data));
			end
			results_due = demand_q.size();
		end
	end

endmodule

// ===== tb/sv/rc_pulse_demand_calibrator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC pulse demand calibrator testbench
// Drives directed pulses over the limit cases, then random phases under
// several register settings with bursty items and a stalling receiver.
// A separate checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module rc_pulse_demand_calibrator_tb;
	import rcpdc_pkg::*;

	localparam logic ModeMeasure = 1'b0;
	localparam logic ModeRestart = 1'b1;

	// Indexes past the register list; writes to them must have no effect.
	localparam logic [CfgIdxW-1:0] CfgSpareLo = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgSpareHi = 2'd3;

	localparam int RandomItems = 1325;
	localparam int Phases      = 6;
	localparam int HoldPhase   = 1;
	localparam int LongHold    = 400;
	localparam int IdleLimit   = 5000;
	localparam int DrainCycles = 60;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	rcpdc_cfg_if    cfg ();
	rcpdc_item_if   item ();
	rcpdc_result_if result ();

	int                fail_count;
	int                results_due;
	int                hold_requests = 0;
	logic [WidthW-1:0] set_shortest = StartShortestRst;
	logic [WidthW-1:0] set_longest  = StartLongestRst;

	rc_pulse_demand_calibrator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.result (result)
	);

	rc_pulse_demand_calibrator_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.item        (item),
		.result      (result),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic item_t measured(input logic [WidthW-1:0] rise, input logic [WidthW-1:0] width);
		item_t x;
		x.mode         = ModeMeasure;
		x.rise_capture = rise;
		x.fall_capture = rise + width;
		return x;
	endfunction

	function automatic item_t restart_with(input logic [WidthW-1:0] rise,
			input logic [WidthW-1:0] fall);
		item_t x;
		x.mode         = ModeRestart;
		x.rise_capture = rise;
		x.fall_capture = fall;
		return x;
	endfunction

	// Mostly pulses around the configured limits, with some noise and restarts.
	function automatic item_t random_item();
		item_t             x;
		int                pick;
		int                lo;
		int                hi;
		logic [WidthW-1:0] width;
		pick = $urandom_range(0, 99);
		lo   = int'((set_shortest < set_longest) ? set_shortest : set_longest);
		hi   = int'((set_shortest < set_longest) ? set_longest : set_shortest);
		if (pick < 6) begin
			x = restart_with(WidthW'($urandom), WidthW'($urandom));
		end else if (pick < 16) begin
			x = measured(WidthW'($urandom), WidthW'($urandom));
		end else if (pick < 26) begin
			case ($urandom_range(0, 5))
				0: width = WidthW'(lo);
				1: width = WidthW'(hi);
				2: width = WidthW'(lo - 1);
				3: width = WidthW'(hi + 1);
				4: width = '0;
				default: width = '1;
			endcase
			x = measured(WidthW'($urandom), width);
		end else begin
			lo = (lo < 50) ? 0 : lo - 50;
			hi = (hi > 65485) ? 65535 : hi + 50;
			x  = measured(WidthW'($urandom), WidthW'($urandom_range(lo, hi)));
		end
		return x;
	endfunction

	task automatic wait_idle();
		while (results_due != 0) @(negedge clk);
	endtask

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(input item_t x);
		item.valid <= 1'b1;
		item.data  <= x;
		do @(posedge clk); while (!item.ready);
		@(negedge clk);
	endtask

	task automatic end_burst(input int gap);
		item.valid <= 1'b0;
		repeat (gap + 1) @(negedge clk);
	endtask

	task automatic configure(input logic [WidthW-1:0] shortest, input logic [WidthW-1:0] longest,
			input bit spare);
		logic [CfgIdxW-1:0] idx[4];
		logic [WidthW-1:0]  val[4];
		int                 n;
		wait_idle();
		n = 0;
		if (spare) begin
			idx[n] = CfgSpareLo;
			val[n] = WidthW'($urandom);
			n++;
		end
		if ($urandom_range(0, 1) == 0) begin
			idx[n]   = CfgStartShortest;
			val[n]   = shortest;
			idx[n+1] = CfgStartLongest;
			val[n+1] = longest;
		end else begin
			idx[n]   = CfgStartLongest;
			val[n]   = longest;
			idx[n+1] = CfgStartShortest;
			val[n+1] = shortest;
		end
		n += 2;
		if (spare) begin
			idx[n] = CfgSpareHi;
			val[n] = WidthW'($urandom);
			n++;
		end
		for (int k = 0; k < n; k++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[k];
			cfg.data  <= val[k];
			do @(posedge clk); while (!cfg.ready);
			@(negedge clk);
		end
		cfg.valid    <= 1'b0;
		set_shortest = shortest;
		set_longest  = longest;
	endtask

	// Receiver: random stall ratio that changes now and then, plus one long
	// hold-off whenever the stimulus asks for it.
	initial begin
		int stall_pct;
		int served;
		result.ready = 1'b0;
		stall_pct    = 0;
		served       = 0;
		forever begin
			@(negedge clk);
			if (served != hold_requests) begin
				served = hold_requests;
				result.ready <= 1'b0;
				repeat (LongHold) @(negedge clk);
			end
			if ($urandom_range(0, 63) == 0) begin
				case ($urandom_range(0, 4))
					0, 1: stall_pct = 0;
					2: stall_pct = 25;
					3: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			result.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IdleLimit) begin
			@(posedge clk);
			if ((item.valid && item.ready) || (result.valid && result.ready) ||
					(cfg.valid && cfg.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("rc_pulse_demand_calibrator_tb NOT OK");
		$finish;
	end

	initial begin
		int               sent;
		int               burst;
		int               per_phase;
		logic [WidthW-1:0] sh;
		logic [WidthW-1:0] lg;
		item.valid = 1'b0;
		item.data  = '0;
		cfg.valid  = 1'b0;
		cfg.index  = CfgStartShortest;
		cfg.data   = '0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset limits: in range, on both limits, growth, shrink, wrapped
		// captures and the capture extremes.
		send_item(measured(16'd1000, 16'd1500));
		send_item(measured(16'd3000, 16'd1250));
		send_item(measured(16'd3000, 16'd1750));
		send_item(measured(16'd100, 16'd2000));
		send_item(measured(16'd200, 16'd1000));
		send_item(measured(16'd65000, 16'd1036));
		send_item(measured(16'd0, 16'd0));
		send_item(measured(16'd0, 16'hFFFF));
		send_item(measured(16'hFFFF, 16'd1));
		send_item(restart_with(16'hFFFF, 16'hFFFF));
		send_item(measured(16'hAAAA, 16'd1400));
		end_burst(3);

		// Equal limits give a zero range.
		configure(16'd1500, 16'd1500, 1'b1);
		send_item(restart_with(16'd0, 16'd0));
		send_item(measured(16'd7, 16'd1500));
		send_item(measured(16'd9, 16'd1500));
		end_burst(0);

		// Shortest above longest makes the subtractions wrap.
		configure(16'd2000, 16'd1000, 1'b0);
		send_item(restart_with(16'h5555, 16'hAAAA));
		send_item(measured(16'd0, 16'd1500));
		send_item(measured(16'd0, 16'd1200));
		send_item(restart_with(16'hAAAA, 16'h5555));
		send_item(measured(16'd0, 16'd500));
		end_burst(1);

		configure(16'd0, 16'hFFFF, 1'b1);
		send_item(restart_with(16'd0, 16'hFFFF));
		send_item(measured(16'd1, 16'd0));
		send_item(measured(16'd2, 16'hFFFF));
		send_item(measured(16'd3, 16'h8000));
		end_burst(2);

		configure(16'hFFFF, 16'd0, 1'b0);
		send_item(restart_with(16'd0, 16'd0));
		send_item(measured(16'd4, 16'd0));
		end_burst(0);

		per_phase = RandomItems / Phases;
		for (int p = 0; p < Phases; p++) begin
			case (p)
				0: begin
					sh = StartShortestRst;
					lg = StartLongestRst;
				end
				1: begin
					sh = WidthW'($urandom_range(900, 1300));
					lg = WidthW'($urandom_range(1600, 2200));
				end
				2: begin
					sh = '0;
					lg = '1;
				end
				3: begin
					sh = '1;
					lg = '0;
				end
				4: begin
					sh = WidthW'($urandom_range(1000, 2000));
					lg = sh;
				end
				default: begin
					sh = WidthW'($urandom);
					lg = WidthW'($urandom);
				end
			endcase
			configure(sh, lg, $urandom_range(0, 1) == 1);
			// The receiver holds off while items keep coming, so the block fills.
			if (p == HoldPhase) begin
				hold_requests++;
			end
			sent = 0;
			if ($urandom_range(0, 19) != 0) begin
				send_item(restart_with(WidthW'($urandom), WidthW'($urandom)));
				sent++;
			end
			while (sent < per_phase) begin
				burst = $urandom_range(1, 20);
				for (int k = 0; k < burst && sent < per_phase; k++) begin
					send_item(random_item());
					sent++;
				end
				end_burst(($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) :
					$urandom_range(0, 3));
				if ($urandom_range(0, 29) == 0) begin
					wait_idle();
				end
			end
		end

		wait_idle();
		repeat (DrainCycles) @(negedge clk);
		if (fail_count == 0 && results_due == 0) begin
			$display("rc_pulse_demand_calibrator_tb OK");
		end else begin
			$display("rc_pulse_demand_calibrator_tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== rc_pulse_demand_calibrator.f =====
+incdir+rtl/core
rtl/core/rcpdc_pkg.sv
rtl/core/rcpdc_ifs.sv
rtl/core/rcpdc_div.sv
rtl/core/rc_pulse_demand_calibrator.sv
rtl/core/rcpdc_checker.sv
tb/sv/rc_pulse_demand_calibrator_checker.sv
tb/sv/rc_pulse_demand_calibrator_tb.sv
